>>> sv/bps_pkg.sv
// Shared types, constants and arithmetic helpers for the boid particle step.
// Used by every module of the block but bps_sqrt; depends on nothing.
`default_nettype none

package bps_pkg;

  localparam int FB       = 16;
  localparam int ONE      = 1 << FB;
  localparam int HALF_ONE = ONE / 2;
  localparam int K002     = (ONE + 25) / 50;
  localparam int K01      = (ONE + 5) / 10;
  localparam int K02      = (ONE + 2) / 5;
  localparam int K00005   = (ONE + 1000) / 2000;
  localparam int THRESH   = 100 * ONE;
  localparam int QW       = 24;   // quotient bits of the divider

  localparam logic signed [67:0] MAX32 = 68'sd2147483647;
  localparam logic signed [67:0] MIN32 = -68'sd2147483648;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED   = 3'd0,
    CFG_MIN_SPEED   = 3'd1,
    CFG_SPEED_MULT  = 3'd2,
    CFG_DECAY       = 3'd3,
    CFG_TAIL_LENGTH = 3'd4
  } cfg_idx_t;

  typedef enum logic [5:0] {
    CMD_NOP, CMD_LOAD, CMD_PLACE, CMD_OUT,
    CMD_DIFF, CMD_DSQ, CMD_VSQ, CMD_ACC, CMD_SQRT,
    CMD_PSCALE, CMD_PRND, CMD_PMUL, CMD_PDIV, CMD_PUPD,
    CMD_CRW1, CMD_CRW2, CMD_CRW3, CMD_FEAR1, CMD_FEAR2,
    CMD_VADD, CMD_MX, CMD_MXC, CMD_MN, CMD_MNC,
    CMD_NDIV, CMD_NWR, CMD_LMUL, CMD_LWR, CMD_FMUL, CMD_FWR,
    CMD_SMUL, CMD_SWR, CMD_TMUL, CMD_TWR, CMD_DMUL, CMD_DWR
  } cmd_t;

  typedef enum logic [2:0] {
    COND_PLACE, COND_TICK, COND_PULL, COND_FAR
  } cond_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] axis;
    logic       waits;
    cond_t      cond;
  } uop_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic pull;
    logic far;
    logic busy;
    logic out_free;
  } dp_stat_t;

  localparam logic [6:0] UC_LAST = 7'd76;

  function automatic uop_t mk(input cmd_t c, input logic [1:0] a, input logic w,
                              input cond_t k);
    uop_t u;
    u.cmd = c;
    u.axis = a;
    u.waits = w;
    u.cond = k;
    return u;
  endfunction

  // Step list of one item
  function automatic uop_t ucode(input logic [6:0] s);
    uop_t u;
    case (s)
      7'd0:  u = mk(CMD_PLACE,  2'd0, 1'b0, COND_PLACE);
      7'd1:  u = mk(CMD_DIFF,   2'd0, 1'b0, COND_PULL);
      7'd2:  u = mk(CMD_DIFF,   2'd1, 1'b0, COND_PULL);
      7'd3:  u = mk(CMD_DIFF,   2'd2, 1'b0, COND_PULL);
      7'd4:  u = mk(CMD_DSQ,    2'd0, 1'b0, COND_PULL);
      7'd5:  u = mk(CMD_ACC,    2'd0, 1'b0, COND_PULL);
      7'd6:  u = mk(CMD_DSQ,    2'd1, 1'b0, COND_PULL);
      7'd7:  u = mk(CMD_ACC,    2'd1, 1'b0, COND_PULL);
      7'd8:  u = mk(CMD_DSQ,    2'd2, 1'b0, COND_PULL);
      7'd9:  u = mk(CMD_ACC,    2'd2, 1'b0, COND_PULL);
      7'd10: u = mk(CMD_SQRT,   2'd0, 1'b1, COND_PULL);
      7'd11: u = mk(CMD_PSCALE, 2'd0, 1'b0, COND_PULL);
      7'd12: u = mk(CMD_PRND,   2'd0, 1'b0, COND_FAR);
      7'd13: u = mk(CMD_PMUL,   2'd0, 1'b0, COND_FAR);
      7'd14: u = mk(CMD_PDIV,   2'd0, 1'b1, COND_FAR);
      7'd15: u = mk(CMD_PUPD,   2'd0, 1'b0, COND_FAR);
      7'd16: u = mk(CMD_PMUL,   2'd1, 1'b0, COND_FAR);
      7'd17: u = mk(CMD_PDIV,   2'd1, 1'b1, COND_FAR);
      7'd18: u = mk(CMD_PUPD,   2'd1, 1'b0, COND_FAR);
      7'd19: u = mk(CMD_PMUL,   2'd2, 1'b0, COND_FAR);
      7'd20: u = mk(CMD_PDIV,   2'd2, 1'b1, COND_FAR);
      7'd21: u = mk(CMD_PUPD,   2'd2, 1'b0, COND_FAR);
      7'd22: u = mk(CMD_CRW1,   2'd0, 1'b0, COND_TICK);
      7'd23: u = mk(CMD_CRW2,   2'd0, 1'b0, COND_TICK);
      7'd24: u = mk(CMD_CRW3,   2'd0, 1'b0, COND_TICK);
      7'd25: u = mk(CMD_FEAR1,  2'd0, 1'b0, COND_TICK);
      7'd26: u = mk(CMD_FEAR2,  2'd0, 1'b0, COND_TICK);
      7'd27: u = mk(CMD_VADD,   2'd0, 1'b0, COND_TICK);
      7'd28: u = mk(CMD_VADD,   2'd1, 1'b0, COND_TICK);
      7'd29: u = mk(CMD_VADD,   2'd2, 1'b0, COND_TICK);
      7'd30: u = mk(CMD_VSQ,    2'd0, 1'b0, COND_TICK);
      7'd31: u = mk(CMD_ACC,    2'd0, 1'b0, COND_TICK);
      7'd32: u = mk(CMD_VSQ,    2'd1, 1'b0, COND_TICK);
      7'd33: u = mk(CMD_ACC,    2'd1, 1'b0, COND_TICK);
      7'd34: u = mk(CMD_VSQ,    2'd2, 1'b0, COND_TICK);
      7'd35: u = mk(CMD_ACC,    2'd2, 1'b0, COND_TICK);
      7'd36: u = mk(CMD_SQRT,   2'd0, 1'b1, COND_TICK);
      7'd37: u = mk(CMD_MX,     2'd0, 1'b0, COND_TICK);
      7'd38: u = mk(CMD_MXC,    2'd0, 1'b0, COND_TICK);
      7'd39: u = mk(CMD_MN,     2'd0, 1'b0, COND_TICK);
      7'd40: u = mk(CMD_MNC,    2'd0, 1'b0, COND_TICK);
      7'd41: u = mk(CMD_NDIV,   2'd0, 1'b1, COND_TICK);
      7'd42: u = mk(CMD_NWR,    2'd0, 1'b0, COND_TICK);
      7'd43: u = mk(CMD_NDIV,   2'd1, 1'b1, COND_TICK);
      7'd44: u = mk(CMD_NWR,    2'd1, 1'b0, COND_TICK);
      7'd45: u = mk(CMD_NDIV,   2'd2, 1'b1, COND_TICK);
      7'd46: u = mk(CMD_NWR,    2'd2, 1'b0, COND_TICK);
      7'd47: u = mk(CMD_LMUL,   2'd0, 1'b0, COND_TICK);
      7'd48: u = mk(CMD_LWR,    2'd0, 1'b0, COND_TICK);
      7'd49: u = mk(CMD_LMUL,   2'd1, 1'b0, COND_TICK);
      7'd50: u = mk(CMD_LWR,    2'd1, 1'b0, COND_TICK);
      7'd51: u = mk(CMD_LMUL,   2'd2, 1'b0, COND_TICK);
      7'd52: u = mk(CMD_LWR,    2'd2, 1'b0, COND_TICK);
      7'd53: u = mk(CMD_FMUL,   2'd0, 1'b0, COND_TICK);
      7'd54: u = mk(CMD_FWR,    2'd0, 1'b0, COND_TICK);
      7'd55: u = mk(CMD_FMUL,   2'd1, 1'b0, COND_TICK);
      7'd56: u = mk(CMD_FWR,    2'd1, 1'b0, COND_TICK);
      7'd57: u = mk(CMD_FMUL,   2'd2, 1'b0, COND_TICK);
      7'd58: u = mk(CMD_FWR,    2'd2, 1'b0, COND_TICK);
      7'd59: u = mk(CMD_SMUL,   2'd0, 1'b0, COND_TICK);
      7'd60: u = mk(CMD_SWR,    2'd0, 1'b0, COND_TICK);
      7'd61: u = mk(CMD_SMUL,   2'd1, 1'b0, COND_TICK);
      7'd62: u = mk(CMD_SWR,    2'd1, 1'b0, COND_TICK);
      7'd63: u = mk(CMD_SMUL,   2'd2, 1'b0, COND_TICK);
      7'd64: u = mk(CMD_SWR,    2'd2, 1'b0, COND_TICK);
      7'd65: u = mk(CMD_TMUL,   2'd0, 1'b0, COND_TICK);
      7'd66: u = mk(CMD_TWR,    2'd0, 1'b0, COND_TICK);
      7'd67: u = mk(CMD_TMUL,   2'd1, 1'b0, COND_TICK);
      7'd68: u = mk(CMD_TWR,    2'd1, 1'b0, COND_TICK);
      7'd69: u = mk(CMD_TMUL,   2'd2, 1'b0, COND_TICK);
      7'd70: u = mk(CMD_TWR,    2'd2, 1'b0, COND_TICK);
      7'd71: u = mk(CMD_DMUL,   2'd0, 1'b0, COND_TICK);
      7'd72: u = mk(CMD_DWR,    2'd0, 1'b0, COND_TICK);
      7'd73: u = mk(CMD_DMUL,   2'd1, 1'b0, COND_TICK);
      7'd74: u = mk(CMD_DWR,    2'd1, 1'b0, COND_TICK);
      7'd75: u = mk(CMD_DMUL,   2'd2, 1'b0, COND_TICK);
      7'd76: u = mk(CMD_DWR,    2'd2, 1'b0, COND_TICK);
      default: u = mk(CMD_NOP,  2'd0, 1'b0, COND_PLACE);
    endcase
    return u;
  endfunction

  function automatic logic signed [67:0] sx32(input logic signed [31:0] v);
    return {{36{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = 32'sh7fffffff;
    else if (v < MIN32) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Drop FB fraction bits, round half away from zero
  function automatic logic signed [67:0] fround(input logic signed [67:0] p);
    logic [67:0] m;
    logic [67:0] q;
    m = p[67] ? 68'(-p) : 68'(p);
    q = (m + 68'(HALF_ONE)) >> FB;
    return p[67] ? $signed(-q) : $signed(q);
  endfunction

endpackage

`default_nettype wire

>>> sv/bps_sqrt.sv
// Iterative floored square root of a 64-bit word, one result bit a cycle.
// Uses nothing from the package.
`default_nettype none

module bps_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             busy,
  output logic [31:0]      root
);

  logic        busy_r;
  logic [63:0] x_r, r_r, bit_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[31:0];

endmodule

`default_nettype wire

>>> sv/bps_div.sv
// Restoring divider: (num + den/2) / den, one quotient bit a cycle.
// Quotient is known to fit bps_pkg::QW bits.
`default_nettype none

module bps_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [63:0]            num,
  input  wire logic [31:0]            den,
  output logic                        busy,
  output logic [bps_pkg::QW-1:0]      quo
);

  logic                   busy_r;
  logic [4:0]             cnt_r;
  logic [32:0]            rem_r;
  logic [bps_pkg::QW-1:0] lo_r;
  logic [64:0]            n0;
  logic [33:0]            t;
  logic                   take;

  assign n0   = {1'b0, num} + {34'b0, den[31:1]};
  assign t    = {rem_r, lo_r[bps_pkg::QW-1]};
  assign take = t >= {2'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(bps_pkg::QW - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n0[bps_pkg::QW+32:bps_pkg::QW];
      lo_r  <= n0[bps_pkg::QW-1:0];
    end else if (busy_r) begin
      rem_r <= take ? 33'(t - {2'b0, den}) : t[32:0];
      lo_r  <= {lo_r[bps_pkg::QW-2:0], take};
    end
  end

  assign busy = busy_r;
  assign quo  = lo_r;

endmodule

`default_nettype wire

>>> sv/bps_dp.sv
// Datapath: particle state, config registers, shared multiplier, sqrt and
// divider units, output register. Depends on bps_pkg, bps_sqrt, bps_div.
`default_nettype none

module bps_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bps_pkg::dp_cmd_t   cmd,
  output bps_pkg::dp_stat_t       stat,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [20:0]        cfg_data,
  input  wire logic               in_op,
  input  wire logic               in_flatten,
  input  wire logic               in_pull_enable,
  input  wire logic [9:0]         in_neighbor_count,
  input  wire logic signed [31:0] in_vec_a_x,
  input  wire logic signed [31:0] in_vec_a_y,
  input  wire logic signed [31:0] in_vec_a_z,
  input  wire logic signed [31:0] in_vec_b_x,
  input  wire logic signed [31:0] in_vec_b_y,
  input  wire logic signed [31:0] in_vec_b_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_tail_x,
  output logic signed [31:0]      out_tail_y,
  output logic signed [31:0]      out_tail_z
);

  // config
  logic [20:0] max_speed_r, min_speed_r, speed_mult_r, tail_len_r;
  logic [16:0] decay_r;

  // latched input word
  logic              op_r, flat_r, pull_r;
  logic [9:0]        n_r;
  logic signed [31:0] va_r [3];
  logic signed [31:0] vb_r [3];

  // particle state and scratch
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] d_r   [3];
  logic signed [31:0] tail_r[3];
  logic signed [17:0] nrm_r [3];
  logic [16:0]        crowd_r, fear_r;
  logic [63:0]        acc_r;
  logic [23:0]        s_r;
  logic signed [67:0] prod_r;
  logic               far_r, gt_r, lim_en_r, sgn_r;

  logic               out_valid_r;
  logic signed [31:0] opos_r [3];
  logic signed [31:0] otail_r[3];

  logic [1:0]         ax;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] rnd;
  logic [21:0]        maxs, lim;
  logic               sq_start, sq_busy, dv_start, dv_busy;
  logic [31:0]        root;
  logic [63:0]        dv_num;
  logic [bps_pkg::QW-1:0] quo;
  logic signed [67:0] qs;
  logic signed [67:0] crowd_w;
  logic               out_take;

  assign ax       = cmd.axis;
  assign rnd      = bps_pkg::fround(prod_r);
  assign maxs     = {1'b0, max_speed_r} + {5'b0, crowd_r};
  assign lim      = gt_r ? maxs : {1'b0, min_speed_r};
  assign qs       = sgn_r ? -$signed({44'b0, quo}) : $signed({44'b0, quo});
  assign crowd_w  = $signed({51'b0, crowd_r}) - rnd;
  assign out_take = out_valid_r && !out_stall;

  assign sq_start = (cmd.cmd == bps_pkg::CMD_SQRT);
  assign dv_start = (cmd.cmd == bps_pkg::CMD_PDIV) || (cmd.cmd == bps_pkg::CMD_NDIV);

  always_comb begin
    dv_num = '0;
    if (cmd.cmd == bps_pkg::CMD_PDIV) begin
      dv_num = prod_r[67] ? 64'(-prod_r) : prod_r[63:0];
    end else begin
      dv_num = vel_r[ax][31] ? {16'b0, 32'(-vel_r[ax]), 16'b0}
                             : {16'b0, vel_r[ax], 16'b0};
    end
  end

  bps_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (acc_r),
    .busy  (sq_busy),
    .root  (root)
  );

  bps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (root),
    .busy  (dv_busy),
    .quo   (quo)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.cmd)
      bps_pkg::CMD_DSQ: begin
        mul_a = 34'(d_r[ax]);
        mul_b = 34'(d_r[ax]);
      end
      bps_pkg::CMD_VSQ: begin
        mul_a = 34'(vel_r[ax]);
        mul_b = 34'(vel_r[ax]);
      end
      bps_pkg::CMD_PSCALE: begin
        mul_a = $signed({2'b0, root}) - 34'(bps_pkg::THRESH);
        mul_b = 34'(bps_pkg::K00005);
      end
      bps_pkg::CMD_PMUL: begin
        mul_a = 34'(d_r[ax]);
        mul_b = $signed({10'b0, s_r});
      end
      bps_pkg::CMD_CRW1: begin
        mul_a = $signed({24'b0, n_r});
        mul_b = 34'(bps_pkg::K002);
      end
      bps_pkg::CMD_CRW2: begin
        mul_a = $signed({17'b0, crowd_r}) - 34'(bps_pkg::ONE) + prod_r[33:0];
        mul_b = 34'(bps_pkg::K01);
      end
      bps_pkg::CMD_FEAR1: begin
        mul_a = $signed({17'b0, fear_r});
        mul_b = 34'(bps_pkg::K02);
      end
      bps_pkg::CMD_MX: begin
        mul_a = $signed({12'b0, maxs});
        mul_b = $signed({12'b0, maxs});
      end
      bps_pkg::CMD_MN: begin
        mul_a = $signed({13'b0, min_speed_r});
        mul_b = $signed({13'b0, min_speed_r});
      end
      bps_pkg::CMD_LMUL: begin
        mul_a = 34'(nrm_r[ax]);
        mul_b = $signed({12'b0, lim});
      end
      bps_pkg::CMD_FMUL: begin
        mul_a = 34'(vel_r[ax]);
        mul_b = 34'(bps_pkg::ONE) + $signed({17'b0, fear_r});
      end
      bps_pkg::CMD_SMUL: begin
        mul_a = 34'(vel_r[ax]);
        mul_b = $signed({13'b0, speed_mult_r});
      end
      bps_pkg::CMD_TMUL: begin
        mul_a = 34'(nrm_r[ax]);
        mul_b = $signed({13'b0, tail_len_r});
      end
      bps_pkg::CMD_DMUL: begin
        mul_a = 34'(vel_r[ax]);
        mul_b = $signed({17'b0, decay_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= 21'd98304;
      min_speed_r  <= 21'd22938;
      speed_mult_r <= 21'd0;
      decay_r      <= 17'd64881;
      tail_len_r   <= 21'd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::CFG_MAX_SPEED:   max_speed_r  <= cfg_data;
        bps_pkg::CFG_MIN_SPEED:   min_speed_r  <= cfg_data;
        bps_pkg::CFG_SPEED_MULT:  speed_mult_r <= cfg_data;
        bps_pkg::CFG_DECAY:       decay_r      <= cfg_data[16:0];
        bps_pkg::CFG_TAIL_LENGTH: tail_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.cmd == bps_pkg::CMD_LOAD) begin
      op_r    <= in_op;
      flat_r  <= in_flatten;
      pull_r  <= in_pull_enable;
      n_r     <= in_neighbor_count;
      va_r[0] <= in_vec_a_x;
      va_r[1] <= in_vec_a_y;
      va_r[2] <= in_vec_a_z;
      vb_r[0] <= in_vec_b_x;
      vb_r[1] <= in_vec_b_y;
      vb_r[2] <= in_vec_b_z;
    end
  end

  // particle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      crowd_r <= 17'(bps_pkg::ONE);
      fear_r  <= 17'(bps_pkg::ONE);
    end else begin
      case (cmd.cmd)
        bps_pkg::CMD_PLACE: begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= vb_r[i];
            vel_r[i] <= va_r[i];
          end
          crowd_r <= 17'(bps_pkg::ONE);
          fear_r  <= 17'(bps_pkg::ONE);
        end
        bps_pkg::CMD_PUPD: vel_r[ax] <= bps_pkg::sat32(bps_pkg::sx32(vel_r[ax]) - qs);
        bps_pkg::CMD_CRW3: begin
          if (crowd_w < 68'(bps_pkg::HALF_ONE)) crowd_r <= 17'(bps_pkg::HALF_ONE);
          else if (crowd_w > 68'(bps_pkg::ONE)) crowd_r <= 17'(bps_pkg::ONE);
          else crowd_r <= crowd_w[16:0];
        end
        bps_pkg::CMD_FEAR2: fear_r <= fear_r - rnd[16:0];
        bps_pkg::CMD_VADD: begin
          if (flat_r && ax == 2'd2) vel_r[ax] <= vel_r[ax];
          else vel_r[ax] <= bps_pkg::sat32(bps_pkg::sx32(vel_r[ax])
                                           + bps_pkg::sx32(va_r[ax]));
        end
        bps_pkg::CMD_LWR: if (lim_en_r) vel_r[ax] <= bps_pkg::sat32(rnd);
        bps_pkg::CMD_FWR: vel_r[ax] <= bps_pkg::sat32(rnd);
        bps_pkg::CMD_SWR: begin
          if (flat_r && ax == 2'd2) pos_r[ax] <= '0;
          else pos_r[ax] <= bps_pkg::sat32(bps_pkg::sx32(pos_r[ax]) + rnd);
        end
        bps_pkg::CMD_DWR: vel_r[ax] <= bps_pkg::sat32(rnd);
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    case (cmd.cmd)
      bps_pkg::CMD_PLACE: begin
        for (int i = 0; i < 3; i++) tail_r[i] <= vb_r[i];
      end
      bps_pkg::CMD_DIFF: begin
        d_r[ax] <= bps_pkg::sat32(bps_pkg::sx32(pos_r[ax]) - bps_pkg::sx32(vb_r[ax]));
        if (ax == 2'd0) acc_r <= '0;
      end
      bps_pkg::CMD_VADD: if (ax == 2'd0) acc_r <= '0;
      bps_pkg::CMD_ACC:    acc_r <= acc_r + prod_r[63:0];
      bps_pkg::CMD_PSCALE: far_r <= {1'b0, root} > 33'(bps_pkg::THRESH);
      bps_pkg::CMD_PRND:   s_r <= rnd[23:0];
      bps_pkg::CMD_PDIV:   sgn_r <= prod_r[67];
      bps_pkg::CMD_NDIV:   sgn_r <= vel_r[ax][31];
      bps_pkg::CMD_MXC:    gt_r <= acc_r > prod_r[63:0];
      bps_pkg::CMD_MNC:    lim_en_r <= gt_r || (acc_r < prod_r[63:0]);
      bps_pkg::CMD_NWR:    nrm_r[ax] <= (root == '0) ? '0 : qs[17:0];
      bps_pkg::CMD_TWR:
        tail_r[ax] <= bps_pkg::sat32(bps_pkg::sx32(pos_r[ax]) - rnd);
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cmd == bps_pkg::CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd == bps_pkg::CMD_OUT) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i]  <= pos_r[i];
        otail_r[i] <= tail_r[i];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = opos_r[0];
  assign out_pos_y  = opos_r[1];
  assign out_pos_z  = opos_r[2];
  assign out_tail_x = otail_r[0];
  assign out_tail_y = otail_r[1];
  assign out_tail_z = otail_r[2];

  assign stat.op       = op_r;
  assign stat.pull     = pull_r;
  assign stat.far      = far_r;
  assign stat.busy     = sq_busy || dv_busy;
  assign stat.out_free = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  a_crowd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (crowd_r >= 17'(bps_pkg::HALF_ONE)) && (crowd_r <= 17'(bps_pkg::ONE)))
    else $error("crowd factor out of range");
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_busy && dv_busy))
    else $error("sqrt and divider busy together");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_start || dv_start) |-> !(sq_busy || dv_busy))
    else $error("unit started while busy");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmd == bps_pkg::CMD_OUT) |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

>>> sv/bps_ctrl.sv
// Controller: accepts a word, walks the step list from bps_pkg::ucode,
// waits on the iterative units and hands the result to the output register.
`default_nettype none

module bps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output bps_pkg::dp_cmd_t       cmd,
  input  wire bps_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [6:0]    step_r, step_nxt;
  bps_pkg::uop_t u;
  logic          cond_ok;

  assign u = bps_pkg::ucode(step_r);

  always_comb begin
    case (u.cond)
      bps_pkg::COND_PLACE: cond_ok = stat.op;
      bps_pkg::COND_TICK:  cond_ok = !stat.op;
      bps_pkg::COND_PULL:  cond_ok = !stat.op && stat.pull;
      bps_pkg::COND_FAR:   cond_ok = !stat.op && stat.pull && stat.far;
      default:             cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.cmd   = bps_pkg::CMD_NOP;
    cmd.axis  = 2'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cmd   = bps_pkg::CMD_LOAD;
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cond_ok) begin
          cmd.cmd  = u.cmd;
          cmd.axis = u.axis;
        end
        if (cond_ok && u.waits) begin
          state_nxt = S_WAIT;
        end else if (step_r == bps_pkg::UC_LAST) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      S_WAIT: begin
        if (!stat.busy) begin
          if (step_r == bps_pkg::UC_LAST) begin
            state_nxt = S_DONE;
          end else begin
            step_nxt  = step_r + 7'd1;
            state_nxt = S_RUN;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.cmd   = bps_pkg::CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> sv/boid_particle_step.sv
// Boid particle step, Q16.16. One word at a time: every word, a place word
// or a tick, makes one pass over the 77-entry step list. A tick with pull
// takes longer than one without, and longer still when the particle lies
// beyond the pull distance and the velocity gets pulled. The time is set by
// the step list, the bit-serial square root (once or twice per tick) and the
// bit-serial divider (three or six times per tick). A finished word waits in
// the output register while the next word is taken in. Config writes are
// always ready. Depends on bps_pkg, bps_ctrl, bps_dp.
`default_nettype none

module boid_particle_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [20:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic               in_flatten,
  input  wire logic               in_pull_enable,
  input  wire logic [9:0]         in_neighbor_count,
  input  wire logic signed [31:0] in_vec_a_x,
  input  wire logic signed [31:0] in_vec_a_y,
  input  wire logic signed [31:0] in_vec_a_z,
  input  wire logic signed [31:0] in_vec_b_x,
  input  wire logic signed [31:0] in_vec_b_y,
  input  wire logic signed [31:0] in_vec_b_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [31:0]      out_tail_x,
  output logic signed [31:0]      out_tail_y,
  output logic signed [31:0]      out_tail_z
);

  bps_pkg::dp_cmd_t  cmd;
  bps_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  bps_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_flatten        (in_flatten),
    .in_pull_enable    (in_pull_enable),
    .in_neighbor_count (in_neighbor_count),
    .in_vec_a_x        (in_vec_a_x),
    .in_vec_a_y        (in_vec_a_y),
    .in_vec_a_z        (in_vec_a_z),
    .in_vec_b_x        (in_vec_b_x),
    .in_vec_b_y        (in_vec_b_y),
    .in_vec_b_z        (in_vec_b_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_tail_x        (out_tail_x),
    .out_tail_y        (out_tail_y),
    .out_tail_z        (out_tail_z)
  );

endmodule

`default_nettype wire
